FILE: hdl/stmc_pkg.sv
`default_nettype none
package stmc_pkg;

  localparam int unsigned POS_W  = 8;
  localparam int unsigned WAIT_W = 9;

  localparam logic [WAIT_W-1:0] POWER_OFF_WAIT = 9'd500;
  localparam logic [WAIT_W-1:0] POWER_ON_WAIT  = 9'd300;

  // input opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // reported motion status codes
  localparam logic [1:0] STATUS_CLOSED   = 2'd0;
  localparam logic [1:0] STATUS_CLOSING  = 2'd1;
  localparam logic [1:0] STATUS_THROWN   = 2'd2;
  localparam logic [1:0] STATUS_THROWING = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_THROW_POSITION   = 3'd0;
  localparam logic [2:0] CFG_STEP_INTERVAL    = 3'd1;
  localparam logic [2:0] CFG_INVERT_OPERATION = 3'd2;
  localparam logic [2:0] CFG_INVERT_POWER     = 3'd3;
  localparam logic [2:0] CFG_INVERT_FROG      = 3'd4;
  localparam logic [2:0] CFG_POWER_PRESENT    = 3'd5;
  localparam logic [2:0] CFG_FROG_PRESENT     = 3'd6;
  localparam logic [2:0] CFG_START_THROWN     = 3'd7;

  typedef enum logic [3:0] {
    ST_CLOSED   = 4'b0001,
    ST_CLOSING  = 4'b0010,
    ST_THROWN   = 4'b0100,
    ST_THROWING = 4'b1000
  } motion_state_t;

  typedef struct packed {
    logic [POS_W-1:0] servo_position;
    logic             servo_enabled;
    logic             power_level;
    logic             frog_level;
    logic [1:0]       motion_status;
    logic             reported_active;
    logic             changed;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/stmc_if.sv
`default_nettype none
interface stmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       request_active;

  modport source (output valid, output opcode, output request_active, input ready);
  modport sink   (input valid, input opcode, input request_active, output ready);
endinterface

interface stmc_out_if;
  logic                      valid;
  logic                      ready;
  logic [stmc_pkg::POS_W-1:0] servo_position;
  logic                      servo_enabled;
  logic                      power_level;
  logic                      frog_level;
  logic [1:0]                motion_status;
  logic                      reported_active;
  logic                      changed;

  modport source (output valid, output servo_position, output servo_enabled,
                  output power_level, output frog_level, output motion_status,
                  output reported_active, output changed, input ready);
  modport sink   (input valid, input servo_position, input servo_enabled,
                  input power_level, input frog_level, input motion_status,
                  input reported_active, input changed, output ready);
endinterface
`default_nettype wire

FILE: hdl/servo_turnout_motion_controller_core.sv
`default_nettype none
// Servo turnout motion controller.
// in_bus carries one beat per command: a one-millisecond tick, a state
// request (request_active) or an init. Every accepted beat yields exactly one
// result beat on out_bus with the servo position, power and frog levels,
// motion status, reported decoder state and a changed flag, all showing the
// state after that command.
// Each result is registered, in the result register or, on a stall, the skid.
// Throughput: one beat per cycle while in_bus.ready is high; the whole state
// update is a single compare/decrement/step pass between the state registers
// and the result register.
// A two-deep output stage (result register plus skid register) lets the block
// take one more beat while a result waits; in_bus.ready drops only when both
// are full, and rises again once out_bus has taken a beat. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must do so only while
// idle, as the block does not enforce it. Reset (rst_n low, synchronous)
// restores the register defaults, puts the turnout closed at position zero,
// unpowered, power pin high, frog pin low, and empties the output stage.
module servo_turnout_motion_controller_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  stmc_in_if.sink         in_bus,
  stmc_out_if.source      out_bus
);

  // configuration
  logic [stmc_pkg::POS_W-1:0] throw_position_r;
  logic [7:0]                 step_interval_r;
  logic invert_operation_r, invert_power_r, invert_frog_r;
  logic power_present_r, frog_present_r, start_thrown_r;

  // turnout state
  stmc_pkg::motion_state_t     state_r, state_nxt;
  logic [stmc_pkg::POS_W-1:0]  position_r, position_nxt;
  logic [stmc_pkg::WAIT_W-1:0] wait_left_r, wait_left_nxt, wait_dec;
  logic powered_r, powered_nxt;
  logic power_out_r, power_out_nxt;
  logic frog_out_r, frog_out_nxt;
  logic changed;
  logic to_thrown, want_thrown, goal_thrown, origin_thrown;
  logic [stmc_pkg::POS_W-1:0] target;

  // output stage
  stmc_pkg::result_t result, out_data_r, skid_data_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire;

  assign in_bus.ready = !skid_valid_r;
  assign in_fire      = in_bus.valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      throw_position_r   <= 8'd90;
      step_interval_r    <= 8'd10;
      invert_operation_r <= 1'b0;
      invert_power_r     <= 1'b0;
      invert_frog_r      <= 1'b0;
      power_present_r    <= 1'b0;
      frog_present_r     <= 1'b0;
      start_thrown_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stmc_pkg::CFG_THROW_POSITION:   throw_position_r   <= cfg_wdata;
        stmc_pkg::CFG_STEP_INTERVAL:    step_interval_r    <= cfg_wdata;
        stmc_pkg::CFG_INVERT_OPERATION: invert_operation_r <= cfg_wdata[0];
        stmc_pkg::CFG_INVERT_POWER:     invert_power_r     <= cfg_wdata[0];
        stmc_pkg::CFG_INVERT_FROG:      invert_frog_r      <= cfg_wdata[0];
        stmc_pkg::CFG_POWER_PRESENT:    power_present_r    <= cfg_wdata[0];
        stmc_pkg::CFG_FROG_PRESENT:     frog_present_r     <= cfg_wdata[0];
        stmc_pkg::CFG_START_THROWN:     start_thrown_r     <= cfg_wdata[0];
      endcase
    end
  end

  assign wait_dec    = (wait_left_r != '0) ? wait_left_r - 1'b1 : '0;
  assign to_thrown   = (state_r == stmc_pkg::ST_THROWING);
  assign target      = to_thrown ? throw_position_r : '0;
  assign want_thrown = in_bus.request_active ^ invert_operation_r;
  assign goal_thrown = (state_r == stmc_pkg::ST_THROWN) || (state_r == stmc_pkg::ST_THROWING);

  always_comb begin
    state_nxt     = state_r;
    position_nxt  = position_r;
    wait_left_nxt = wait_left_r;
    powered_nxt   = powered_r;
    power_out_nxt = power_out_r;
    frog_out_nxt  = frog_out_r;
    changed       = 1'b0;
    unique case (in_bus.opcode)
      stmc_pkg::OP_TICK: begin
        wait_left_nxt = wait_dec;
        if (state_r == stmc_pkg::ST_CLOSED || state_r == stmc_pkg::ST_THROWN) begin
          // settled: drop power once the hold time runs out
          if (powered_r && wait_dec == '0) begin
            powered_nxt = 1'b0;
            if (power_present_r) power_out_nxt = !invert_power_r;
          end
        end else if (position_r == target) begin
          wait_left_nxt = stmc_pkg::POWER_OFF_WAIT;
          state_nxt     = to_thrown ? stmc_pkg::ST_THROWN : stmc_pkg::ST_CLOSED;
          if (frog_present_r) frog_out_nxt = to_thrown ^ invert_frog_r;
          changed       = 1'b1;
        end else if (wait_dec == '0) begin
          position_nxt  = to_thrown ? position_r + 1'b1 : position_r - 1'b1;
          wait_left_nxt = {1'b0, step_interval_r};
        end
      end
      stmc_pkg::OP_REQUEST: begin
        if (want_thrown != goal_thrown) begin
          powered_nxt   = 1'b1;
          wait_left_nxt = stmc_pkg::POWER_ON_WAIT;
          if (power_present_r) power_out_nxt = invert_power_r;
          state_nxt     = want_thrown ? stmc_pkg::ST_THROWING : stmc_pkg::ST_CLOSING;
          changed       = 1'b1;
        end
      end
      stmc_pkg::OP_INIT: begin
        // power off then straight back on: only the power-on level remains
        powered_nxt   = 1'b1;
        wait_left_nxt = stmc_pkg::POWER_ON_WAIT;
        if (power_present_r) power_out_nxt = invert_power_r;
        position_nxt  = start_thrown_r ? throw_position_r : '0;
        state_nxt     = start_thrown_r ? stmc_pkg::ST_THROWING : stmc_pkg::ST_CLOSING;
      end
      stmc_pkg::OP_UNUSED: begin
      end
    endcase
  end

  assign origin_thrown = (state_nxt == stmc_pkg::ST_THROWN) ||
                         (state_nxt == stmc_pkg::ST_CLOSING);

  always_comb begin
    result.servo_position  = position_nxt;
    result.servo_enabled   = powered_nxt;
    result.power_level     = power_out_nxt;
    result.frog_level      = frog_out_nxt;
    result.reported_active = origin_thrown ^ invert_operation_r;
    result.changed         = changed;
    unique case (state_nxt)
      stmc_pkg::ST_CLOSED:   result.motion_status = stmc_pkg::STATUS_CLOSED;
      stmc_pkg::ST_CLOSING:  result.motion_status = stmc_pkg::STATUS_CLOSING;
      stmc_pkg::ST_THROWN:   result.motion_status = stmc_pkg::STATUS_THROWN;
      stmc_pkg::ST_THROWING: result.motion_status = stmc_pkg::STATUS_THROWING;
      default:               result.motion_status = stmc_pkg::STATUS_CLOSED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stmc_pkg::ST_CLOSED;
      position_r  <= '0;
      wait_left_r <= '0;
      powered_r   <= 1'b0;
      power_out_r <= 1'b1;
      frog_out_r  <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      wait_left_r <= wait_left_nxt;
      powered_r   <= powered_nxt;
      power_out_r <= power_out_nxt;
      frog_out_r  <= frog_out_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_bus.ready) begin
        out_valid_r  <= skid_valid_r || in_fire;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_bus.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (out_valid_r && !out_bus.ready && in_fire) begin
      skid_data_r <= result;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.servo_position  = out_data_r.servo_position;
  assign out_bus.servo_enabled   = out_data_r.servo_enabled;
  assign out_bus.power_level     = out_data_r.power_level;
  assign out_bus.frog_level      = out_data_r.frog_level;
  assign out_bus.motion_status   = out_data_r.motion_status;
  assign out_bus.reported_active = out_data_r.reported_active;
  assign out_bus.changed         = out_data_r.changed;

endmodule
`default_nettype wire

FILE: hdl/stmc_checker.sv
`default_nettype none
module stmc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_servo_position,
  input wire logic       out_servo_enabled,
  input wire logic [1:0] out_motion_status
);

  // a stalled result beat holds its position
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_servo_position))
    else $error("stalled result beat changed");

  // a beat taken into an empty output stage shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result beat missing one cycle after input");

  // input backpressure only while results are pending
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output stage");

  // a moving turnout is always powered
  a_moving_powered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion_status == stmc_pkg::STATUS_CLOSING ||
                  out_motion_status == stmc_pkg::STATUS_THROWING) |-> out_servo_enabled)
    else $error("moving turnout reported unpowered");

  // reset empties the output stage
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind servo_turnout_motion_controller_core stmc_checker u_stmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_servo_position(out_bus.servo_position),
  .out_servo_enabled (out_bus.servo_enabled),
  .out_motion_status (out_bus.motion_status)
);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stmc_pkg::*;

  typedef struct {
    logic [1:0] opcode;
    logic       request_active;
  } command_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  stmc_in_if  in_bus ();
  stmc_out_if out_bus ();

  servo_turnout_motion_controller_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  // turnout model state
  motion_state_t     turnout_state;
  logic [POS_W-1:0]  servo_pos;
  logic [WAIT_W-1:0] wait_ticks;
  logic              servo_on;
  logic              power_pin;
  logic              frog_pin;

  // register copies
  logic [7:0] throw_end;
  logic [7:0] step_ticks;
  logic       invert_op;
  logic       invert_pwr;
  logic       invert_frog;
  logic       has_power_sw;
  logic       has_frog_sw;
  logic       init_at_thrown;

  command_t cmd_queue[$];
  result_t  predicted_status[$];
  result_t  got;
  result_t  want;
  string    diff;

  int cmds_issued   = 0;
  int phase_cmds    = 0;
  int beats_checked = 0;
  int moves_seen    = 0;
  int power_downs   = 0;
  int mismatches    = 0;
  int setups        = 0;

  logic in_took     = 1'b0;
  logic out_took    = 1'b0;
  int   in_hold     = 0;
  int   in_mode_left = 0;
  logic in_gaps_on  = 1'b0;
  int   out_hold    = 0;
  int   out_mode_left = 0;
  logic out_gaps_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic goal_thrown_now();
    return turnout_state == ST_THROWN || turnout_state == ST_THROWING;
  endfunction

  task automatic drop_power();
    if (has_power_sw) power_pin = ~invert_pwr;
    servo_on = 1'b0;
  endtask

  task automatic raise_power();
    if (has_power_sw) power_pin = invert_pwr;
    servo_on   = 1'b1;
    wait_ticks = POWER_ON_WAIT;
  endtask

  task automatic advance_turnout(input logic [1:0] op, input logic req, output result_t r);
    logic       to_thrown;
    logic       origin_thrown;
    logic       chg;
    logic [7:0] target;
    chg = 1'b0;
    case (op)
      OP_TICK: begin
        if (wait_ticks != 0) wait_ticks = wait_ticks - 1'b1;
        if (turnout_state == ST_CLOSED || turnout_state == ST_THROWN) begin
          if (servo_on && wait_ticks == 0) begin
            drop_power();
            power_downs++;
          end
        end else begin
          to_thrown = turnout_state == ST_THROWING;
          target    = to_thrown ? throw_end : 8'd0;
          // arrival wins over the step timer
          if (servo_pos == target) begin
            wait_ticks    = POWER_OFF_WAIT;
            turnout_state = to_thrown ? ST_THROWN : ST_CLOSED;
            if (has_frog_sw) frog_pin = to_thrown ^ invert_frog;
            chg = 1'b1;
          end else if (wait_ticks == 0) begin
            servo_pos  = to_thrown ? servo_pos + 8'd1 : servo_pos - 8'd1;
            wait_ticks = {1'b0, step_ticks};
          end
        end
      end
      OP_REQUEST: begin
        to_thrown = req ^ invert_op;
        if (to_thrown != goal_thrown_now()) begin
          raise_power();
          turnout_state = to_thrown ? ST_THROWING : ST_CLOSING;
          chg = 1'b1;
        end
      end
      OP_INIT: begin
        if (has_power_sw) drop_power();
        servo_pos = init_at_thrown ? throw_end : 8'd0;
        raise_power();
        turnout_state = init_at_thrown ? ST_THROWING : ST_CLOSING;
      end
      default: ;
    endcase
    origin_thrown = turnout_state == ST_THROWN || turnout_state == ST_CLOSING;
    r.servo_position  = servo_pos;
    r.servo_enabled   = servo_on;
    r.power_level     = power_pin;
    r.frog_level      = frog_pin;
    case (turnout_state)
      ST_CLOSED:   r.motion_status = STATUS_CLOSED;
      ST_CLOSING:  r.motion_status = STATUS_CLOSING;
      ST_THROWN:   r.motion_status = STATUS_THROWN;
      default:     r.motion_status = STATUS_THROWING;
    endcase
    r.reported_active = origin_thrown ^ invert_op;
    r.changed         = chg;
  endtask

  // monitor: check the result beat, then predict the command beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  = 1'b0;
      out_took = 1'b0;
    end else begin
      out_took = out_bus.valid && out_bus.ready;
      if (out_took) begin
        got.servo_position  = out_bus.servo_position;
        got.servo_enabled   = out_bus.servo_enabled;
        got.power_level     = out_bus.power_level;
        got.frog_level      = out_bus.frog_level;
        got.motion_status   = out_bus.motion_status;
        got.reported_active = out_bus.reported_active;
        got.changed         = out_bus.changed;
        if (predicted_status.size() == 0) begin
          if (mismatches < 10) $display("result beat %0d arrived with nothing expected",
                                        beats_checked);
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          diff = "";
          if (got.servo_position !== want.servo_position) diff = {diff, " servo_position"};
          if (got.servo_enabled !== want.servo_enabled) diff = {diff, " servo_enabled"};
          if (got.power_level !== want.power_level) diff = {diff, " power_level"};
          if (got.frog_level !== want.frog_level) diff = {diff, " frog_level"};
          if (got.motion_status !== want.motion_status) diff = {diff, " motion_status"};
          if (got.reported_active !== want.reported_active) diff = {diff, " reported_active"};
          if (got.changed !== want.changed) diff = {diff, " changed"};
          if (diff != "") begin
            if (mismatches < 10) begin
              $display("result beat %0d mismatch in%s", beats_checked, diff);
              $display("  expected pos %0d en %b pwr %b frog %b status %0d active %b chg %b",
                       want.servo_position, want.servo_enabled, want.power_level,
                       want.frog_level, want.motion_status, want.reported_active,
                       want.changed);
              $display("  actual   pos %0d en %b pwr %b frog %b status %0d active %b chg %b",
                       got.servo_position, got.servo_enabled, got.power_level,
                       got.frog_level, got.motion_status, got.reported_active,
                       got.changed);
            end
            mismatches++;
          end
          if (want.changed) moves_seen++;
        end
        beats_checked++;
      end
      in_took = in_bus.valid && in_bus.ready;
      if (in_took) begin
        advance_turnout(in_bus.opcode, in_bus.request_active, want);
        predicted_status.push_back(want);
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid          <= 1'b0;
      in_bus.opcode         <= OP_TICK;
      in_bus.request_active <= 1'b0;
    end else if (!in_bus.valid || in_took) begin
      if (in_hold > 0) begin
        in_hold--;
        in_bus.valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        in_bus.valid          <= 1'b1;
        in_bus.opcode         <= cmd_queue[0].opcode;
        in_bus.request_active <= cmd_queue[0].request_active;
        void'(cmd_queue.pop_front());
        if (in_mode_left == 0) begin
          in_gaps_on   = ~in_gaps_on;
          in_mode_left = $urandom_range(20, 150);
        end else begin
          in_mode_left--;
        end
        in_hold = in_gaps_on ? $urandom_range(0, 4) : 0;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result sink: in gap mode, stall a random count after each taken beat
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_took) begin
        if (out_mode_left == 0) begin
          out_gaps_on   = ~out_gaps_on;
          out_mode_left = $urandom_range(20, 150);
        end else begin
          out_mode_left--;
        end
        out_hold = out_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic req);
    command_t c;
    c.opcode         = op;
    c.request_active = req;
    cmd_queue.push_back(c);
    cmds_issued++;
    phase_cmds++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_cmd(OP_TICK, 1'($urandom_range(0, 1)));
  endtask

  // hold until every queued command has produced its result
  task automatic wait_settled();
    while (cmd_queue.size() != 0 || in_bus.valid === 1'b1 || predicted_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_THROW_POSITION:   throw_end      = val;
      CFG_STEP_INTERVAL:    step_ticks     = val;
      CFG_INVERT_OPERATION: invert_op      = val[0];
      CFG_INVERT_POWER:     invert_pwr     = val[0];
      CFG_INVERT_FROG:      invert_frog    = val[0];
      CFG_POWER_PRESENT:    has_power_sw   = val[0];
      CFG_FROG_PRESENT:     has_frog_sw    = val[0];
      default:              init_at_thrown = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // flags: invert_op, invert_pwr, invert_frog, power switch, frog switch, start thrown
  task automatic load_setup(input logic [7:0] tp, input logic [7:0] si, input logic [5:0] f);
    write_reg(CFG_THROW_POSITION, tp);
    write_reg(CFG_STEP_INTERVAL, si);
    write_reg(CFG_INVERT_OPERATION, {7'd0, f[5]});
    write_reg(CFG_INVERT_POWER, {7'd0, f[4]});
    write_reg(CFG_INVERT_FROG, {7'd0, f[3]});
    write_reg(CFG_POWER_PRESENT, {7'd0, f[2]});
    write_reg(CFG_FROG_PRESENT, {7'd0, f[1]});
    write_reg(CFG_START_THROWN, {7'd0, f[0]});
    setups++;
  endtask

  // request one end, then tick long enough to arrive unless cut short
  task automatic travel(input logic to_thrown, input logic may_cut);
    int         n;
    int         span;
    int         steps_left;
    logic [7:0] gap;
    logic       moving;
    span       = (step_ticks == 0) ? 1 : int'(step_ticks);
    gap        = throw_end - servo_pos;
    steps_left = to_thrown ? int'(gap) : int'(servo_pos);
    moving     = turnout_state == ST_CLOSING || turnout_state == ST_THROWING;
    if (to_thrown != goal_thrown_now()) n = int'(POWER_ON_WAIT) + steps_left * span + 2;
    else if (moving) n = int'(wait_ticks) + steps_left * span + 2;
    else n = $urandom_range(1, 40);
    push_cmd(OP_REQUEST, to_thrown ^ invert_op);
    if (may_cut && $urandom_range(0, 3) == 0) n = $urandom_range(0, n);
    if (n > 2000) n = 2000;
    push_ticks(n + $urandom_range(0, 3));
    wait_settled();
  endtask

  task automatic run_phase(input int budget);
    int   pick;
    int   n;
    logic moving;
    phase_cmds = 0;
    while (phase_cmds < budget) begin
      pick   = $urandom_range(0, 9);
      moving = turnout_state == ST_CLOSING || turnout_state == ST_THROWING;
      if (pick <= 5) begin
        travel(($urandom_range(0, 3) != 0) ? !goal_thrown_now() : 1'($urandom_range(0, 1)),
               1'b1);
      end else if (pick <= 7) begin
        // land near the power-down tick when resting powered
        n = (servo_on && !moving) ? int'(wait_ticks) + int'($urandom_range(0, 3)) - 1
                                  : int'($urandom_range(1, 30));
        push_ticks(n);
        wait_settled();
      end else if (pick == 8) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        wait_settled();
      end else begin
        push_cmd(OP_INIT, 1'($urandom_range(0, 1)));
        push_ticks($urandom_range(0, 3));
        wait_settled();
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_THROW_POSITION;
    cfg_wdata             = 8'd0;
    in_bus.valid          = 1'b0;
    in_bus.opcode         = OP_TICK;
    in_bus.request_active = 1'b0;
    out_bus.ready         = 1'b0;
    turnout_state  = ST_CLOSED;
    servo_pos      = '0;
    wait_ticks     = '0;
    servo_on       = 1'b0;
    power_pin      = 1'b1;
    frog_pin       = 1'b0;
    throw_end      = 8'd90;
    step_ticks     = 8'd10;
    invert_op      = 1'b0;
    invert_pwr     = 1'b0;
    invert_frog    = 1'b0;
    has_power_sw   = 1'b0;
    has_frog_sw    = 1'b0;
    init_at_thrown = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: unused opcode, same-end request, interrupted throw
    push_cmd(OP_UNUSED, 1'b1);
    push_cmd(OP_TICK, 1'b0);
    push_cmd(OP_REQUEST, 1'b0);
    push_cmd(OP_REQUEST, 1'b1);
    push_cmd(OP_REQUEST, 1'b1);
    push_cmd(OP_TICK, 1'b1);
    push_cmd(OP_REQUEST, 1'b0);
    push_cmd(OP_TICK, 1'b0);
    push_cmd(OP_TICK, 1'b0);
    wait_settled();

    // everything inverted, both switches present, init at the thrown end
    load_setup(8'd3, 8'd0, 6'b111111);
    push_cmd(OP_INIT, 1'b0);
    push_cmd(OP_TICK, 1'b1);
    push_cmd(OP_REQUEST, 1'b0);
    push_cmd(OP_REQUEST, 1'b1);
    push_cmd(OP_INIT, 1'b1);
    push_cmd(OP_TICK, 1'b0);
    push_cmd(OP_UNUSED, 1'b0);
    wait_settled();
    write_reg(CFG_START_THROWN, 8'd0);
    write_reg(CFG_THROW_POSITION, 8'd255);
    push_cmd(OP_INIT, 1'b1);
    push_cmd(OP_TICK, 1'b0);
    wait_settled();

    // wrap past 255 on the way to a low throw end, then sit out the power-down
    load_setup(8'd250, 8'd0, {5'($urandom_range(0, 31)), 1'b1});
    push_cmd(OP_INIT, 1'b0);
    push_cmd(OP_TICK, 1'b0);
    wait_settled();
    write_reg(CFG_THROW_POSITION, 8'd3);
    push_cmd(OP_REQUEST, invert_op);
    wait_settled();
    travel(1'b1, 1'b0);
    push_ticks(int'(wait_ticks) + 1);
    wait_settled();

    load_setup(8'($urandom_range(1, 8)), 8'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
    run_phase(40);

    wait_settled();
    repeat (4) @(posedge clk);
    $display("Sent %0d commands over %0d register setups, checked %0d result beats.",
             cmds_issued, setups, beats_checked);
    $display("Covered %0d accepted requests or completed moves and %0d power-downs.",
             moves_seen, power_downs);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: servo_turnout_motion_controller_core.f
hdl/stmc_pkg.sv
hdl/stmc_if.sv
hdl/servo_turnout_motion_controller_core.sv
hdl/stmc_checker.sv
tb/tb.sv
